// ===== rtl/sps_pkg.sv =====
package sps_pkg;

    localparam int INIT_ENTRIES_DEF = 8;
    localparam int READ_BYTES_DEF   = 12;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int IDX_W       = 4;

    localparam logic [31:0] POWER_WAIT_MS    = 32'd25;
    localparam logic [31:0] READ_TIMEOUT_MS  = 32'd200;
    localparam logic [1:0]  SETUP_FAIL_LIMIT = 2'd3;
    localparam logic [1:0]  READ_FAIL_LIMIT  = 2'd2;
    localparam logic [7:0]  TABLE_END        = 8'hFF;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_PWRWAIT   = 4'd1,
        PH_SETUP     = 4'd2,
        PH_SETUPWAIT = 4'd3,
        PH_RUN       = 4'd4,
        PH_ADDRWAIT  = 4'd5,
        PH_DATAWAIT  = 4'd6,
        PH_ERROR     = 4'd7,
        PH_BUSRESET  = 4'd8,
        PH_POWEROFF  = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_STOP  = 2'd3
    } bus_cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEVICE_ADDRESS       = 3'd0,
        REG_INIT_TABLE_LOW       = 3'd1,
        REG_INIT_TABLE_HIGH      = 3'd2,
        REG_READ_START_REGISTER  = 3'd3,
        REG_SAMPLE_INTERVAL_MS   = 3'd4,
        REG_IRQ_PRESENT          = 3'd5,
        REG_POWER_SWITCH_PRESENT = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [63:0] init_table_low;
        logic [63:0] init_table_high;
        logic [7:0]  read_start_register;
        logic [7:0]  sample_interval_ms;
        logic        irq_present;
        logic        power_switch_present;
    } cfg_t;

    typedef struct packed {
        logic        start_req;
        logic [31:0] now_ms;
        logic        bus_busy;
        logic        bus_error;
        logic        bus_result_ready;
        logic        irq_level;
    } poll_t;

    typedef struct packed {
        logic [3:0] phase;
        logic [1:0] bus_cmd;
        logic [3:0] bus_len;
        logic [7:0] bus_first_byte;
        logic [7:0] bus_second_byte;
        logic       clear_error;
        logic       take_result;
        logic       power_on;
        logic       filter_reset;
        logic       ready_res;
        logic       new_sample;
        logic       error_seen;
    } result_t;

endpackage

// ===== rtl/sps_poll_if.sv =====
interface sps_poll_if
    import sps_pkg::*;
;
    logic  valid;
    logic  ready;
    poll_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sps_result_if.sv =====
interface sps_result_if
    import sps_pkg::*;
;
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sps_cfg_regs.sv =====
module sps_cfg_regs
    import sps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEVICE_ADDRESS:
                begin
                    // address is used by the bus master only
                end
                REG_INIT_TABLE_LOW:       cfg_next.init_table_low       = cfg_data;
                REG_INIT_TABLE_HIGH:      cfg_next.init_table_high      = cfg_data;
                REG_READ_START_REGISTER:  cfg_next.read_start_register  = cfg_data[7:0];
                REG_SAMPLE_INTERVAL_MS:   cfg_next.sample_interval_ms   = cfg_data[7:0];
                REG_IRQ_PRESENT:          cfg_next.irq_present          = cfg_data[0];
                REG_POWER_SWITCH_PRESENT: cfg_next.power_switch_present = cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.init_table_low       <= '1;
            cfg_reg.init_table_high      <= '1;
            cfg_reg.read_start_register  <= 8'd34;
            cfg_reg.sample_interval_ms   <= 8'd9;
            cfg_reg.irq_present          <= 1'b1;
            cfg_reg.power_switch_present <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/sps_core.sv =====
module sps_core
    import sps_pkg::*;
#(
    parameter int INIT_ENTRIES = INIT_ENTRIES_DEF,
    parameter int READ_BYTES   = READ_BYTES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  poll_t   poll_word,
    input  cfg_t    cfg,
    output result_t res
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(INIT_ENTRIES);
    localparam logic [3:0]       READ_LEN = 4'(READ_BYTES % 16);

    phase_t           mode_reg,        mode_next;
    logic [31:0]      power_time_reg,  power_time_next;
    logic [31:0]      sample_time_reg, sample_time_next;
    logic [IDX_W-1:0] init_index_reg,  init_index_next;
    logic [1:0]       rfc_reg,         rfc_next;
    logic [1:0]       sfc_reg,         sfc_next;
    logic             power_reg,       power_next;
    logic             ready_reg,       ready_next;
    logic             error_reg,       error_next;

    logic [15:0]  entry;
    logic [31:0]  power_elapsed;
    logic [31:0]  sample_elapsed;
    logic [31:0]  interval_m1;
    logic         go;
    logic         ok;
    logic [127:0] table_word;

    always_comb
    begin
        table_word = {cfg.init_table_high, cfg.init_table_low};
        if (init_index_reg >= LAST_IDX || init_index_reg[3])
            entry = {TABLE_END, 8'hFF};
        else
            entry = table_word[{init_index_reg[2:0], 4'd0} +: 16];
    end

    assign power_elapsed  = poll_word.now_ms - power_time_reg;
    assign sample_elapsed = poll_word.now_ms - sample_time_reg;
    assign interval_m1    = {24'd0, cfg.sample_interval_ms} - 32'd1;
    // interrupt may fire one ms early
    assign go = (sample_elapsed >= {24'd0, cfg.sample_interval_ms})
             || (cfg.irq_present && poll_word.irq_level && sample_elapsed >= interval_m1);

    always_comb
    begin
        mode_next        = mode_reg;
        power_time_next  = power_time_reg;
        sample_time_next = sample_time_reg;
        init_index_next  = init_index_reg;
        rfc_next         = rfc_reg;
        sfc_next         = sfc_reg;
        power_next       = power_reg;
        ready_next       = ready_reg;
        error_next       = error_reg;
        ok               = 1'b0;

        res = '0;

        if (poll_word.start_req)
        begin
            if (cfg.power_switch_present)
                power_next = 1'b1;
            mode_next       = PH_PWRWAIT;
            power_time_next = poll_word.now_ms;
            init_index_next = '0;
        end
        else
        begin
            unique case (mode_reg) inside
                PH_PWRWAIT:
                begin
                    if (power_elapsed >= POWER_WAIT_MS)
                    begin
                        mode_next       = PH_SETUP;
                        init_index_next = '0;
                    end
                end
                PH_SETUP:
                begin
                    res.filter_reset = 1'b1;
                    rfc_next         = '0;
                    if (entry[15:8] == TABLE_END)
                    begin
                        ready_next       = 1'b1;
                        mode_next        = PH_RUN;
                        sample_time_next = poll_word.now_ms;
                    end
                    else
                    begin
                        res.bus_cmd         = CMD_WRITE;
                        res.bus_len         = 4'd2;
                        res.bus_first_byte  = entry[15:8];
                        res.bus_second_byte = entry[7:0];
                        mode_next           = PH_SETUPWAIT;
                    end
                end
                PH_SETUPWAIT:
                begin
                    if (!poll_word.bus_busy)
                    begin
                        if (!poll_word.bus_error)
                        begin
                            if (init_index_reg < LAST_IDX)
                                init_index_next = init_index_reg + IDX_W'(1);
                        end
                        else
                        begin
                            res.clear_error = 1'b1;
                            init_index_next = '0;
                            if (sfc_reg < SETUP_FAIL_LIMIT)
                                sfc_next = sfc_reg + 2'd1;
                            error_next = 1'b1;
                        end
                        mode_next = (sfc_next < SETUP_FAIL_LIMIT) ? PH_SETUP : PH_ERROR;
                    end
                end
                PH_RUN:
                begin
                    if (go)
                    begin
                        sample_time_next   = poll_word.now_ms;
                        res.bus_cmd        = CMD_WRITE;
                        res.bus_len        = 4'd1;
                        res.bus_first_byte = cfg.read_start_register;
                        mode_next          = PH_ADDRWAIT;
                    end
                end
                PH_ADDRWAIT, PH_DATAWAIT:
                begin
                    if (mode_reg == PH_ADDRWAIT)
                    begin
                        if (!poll_word.bus_busy && !poll_word.bus_error)
                        begin
                            res.bus_cmd = CMD_READ;
                            res.bus_len = READ_LEN;
                            mode_next   = PH_DATAWAIT;
                            ok          = 1'b1;
                        end
                    end
                    else if (poll_word.bus_result_ready)
                    begin
                        rfc_next        = '0;
                        mode_next       = PH_RUN;
                        res.take_result = 1'b1;
                        res.new_sample  = 1'b1;
                        ok              = 1'b1;
                    end
                    if (!ok && sample_elapsed >= READ_TIMEOUT_MS)
                    begin
                        res.clear_error = 1'b1;
                        if (rfc_reg < READ_FAIL_LIMIT)
                        begin
                            rfc_next  = rfc_reg + 2'd1;
                            mode_next = PH_RUN;
                        end
                        else
                        begin
                            mode_next = PH_ERROR;
                        end
                    end
                end
                PH_ERROR:
                begin
                    error_next      = 1'b1;
                    init_index_next = '0;
                    mode_next       = PH_BUSRESET;
                    power_time_next = poll_word.now_ms;
                    res.bus_cmd     = CMD_STOP;
                end
                PH_BUSRESET:
                begin
                    if (!poll_word.bus_busy)
                    begin
                        power_time_next = poll_word.now_ms;
                        if (cfg.power_switch_present)
                        begin
                            mode_next  = PH_POWEROFF;
                            power_next = 1'b0;
                        end
                        else
                        begin
                            mode_next = PH_PWRWAIT;
                        end
                    end
                end
                PH_POWEROFF:
                begin
                    if (power_elapsed >= POWER_WAIT_MS)
                    begin
                        power_time_next = poll_word.now_ms;
                        power_next      = 1'b1;
                        mode_next       = PH_PWRWAIT;
                    end
                end
                default:
                begin
                end
            endcase
        end

        res.phase      = mode_next;
        res.power_on   = power_next;
        res.ready_res  = ready_next;
        res.error_seen = error_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= PH_IDLE;
            power_time_reg  <= '0;
            sample_time_reg <= '0;
            init_index_reg  <= '0;
            rfc_reg         <= '0;
            sfc_reg         <= '0;
            power_reg       <= 1'b0;
            ready_reg       <= 1'b0;
            error_reg       <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg        <= mode_next;
            power_time_reg  <= power_time_next;
            sample_time_reg <= sample_time_next;
            init_index_reg  <= init_index_next;
            rfc_reg         <= rfc_next;
            sfc_reg         <= sfc_next;
            power_reg       <= power_next;
            ready_reg       <= ready_next;
            error_reg       <= error_next;
        end
    end

endmodule

// ===== rtl/sps_out_stage.sv =====
module sps_out_stage
    import sps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  result_t             load_data,
    output logic                can_load,
    sps_result_if.source        result
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign can_load   = !valid_reg || result.ready;
    assign valid_next = load || (valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign result.valid = valid_reg;
    assign result.data  = data_reg;

endmodule

// ===== rtl/sensor_poll_sequencer.sv =====
// Sensor poll sequencer: takes one poll word per cycle (time, bus status,
// interrupt level) and returns one result word per poll carrying the phase,
// the bus command to issue and the control pulses. Each poll is evaluated
// combinationally against the sequencer state and latched in the output
// register, so the block sustains one word per clock when not stalled;
// the result is valid in the cycle after acceptance; a stalled result blocks
// new polls only while the output register is full and not being taken.
module sensor_poll_sequencer
    import sps_pkg::*;
#(
    parameter int INIT_ENTRIES = INIT_ENTRIES_DEF,
    parameter int READ_BYTES   = READ_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    sps_poll_if.sink               poll,
    sps_result_if.source           result
);

    cfg_t    cfg;
    result_t step_res;
    logic    can_load;
    logic    accept;

    assign poll.ready = can_load;
    assign accept     = poll.valid && can_load;

    sps_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sps_core #(
        .INIT_ENTRIES (INIT_ENTRIES),
        .READ_BYTES   (READ_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .poll_word (poll.data),
        .cfg       (cfg),
        .res       (step_res)
    );

    sps_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (step_res),
        .can_load  (can_load),
        .result    (result)
    );

endmodule

// ===== rtl/sps_checker.sv =====
module sps_checker
    import sps_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    res_valid,
    input logic    res_ready,
    input result_t res_data
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result word changed while stalled");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.bus_cmd == CMD_NONE || res_data.bus_cmd == CMD_STOP)
        |-> res_data.bus_len == 4'd0 && res_data.bus_first_byte == 8'd0
            && res_data.bus_second_byte == 8'd0)
        else $error("transfer fields set without a transfer");

    a_take_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.take_result
        |-> res_data.phase == PH_RUN && res_data.new_sample)
        else $error("sample taken outside run phase");

    a_stop_busreset: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.bus_cmd == CMD_STOP |-> res_data.phase == PH_BUSRESET
            && res_data.error_seen)
        else $error("force stop without bus reset");

endmodule

bind sensor_poll_sequencer sps_checker u_sps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_data  (result.data)
);

// ===== test/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sps_pkg::*;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    cfg_reg_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sps_poll_if poll_bus ();
    sps_result_if result_bus ();

    sensor_poll_sequencer u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .poll(poll_bus),
        .result(result_bus)
    );

    always #5 clk = ~clk;

    // sequencer state as predicted
    phase_t m_mode;
    logic [31:0] m_power_time;
    logic [31:0] m_sample_time;
    logic [3:0] m_init_idx;
    logic [1:0] m_read_fails;
    logic [1:0] m_setup_fails;
    logic m_power;
    logic m_ready;
    logic m_error;

    // configuration as predicted
    logic [63:0] c_table_lo;
    logic [63:0] c_table_hi;
    logic [7:0] c_read_reg;
    logic [7:0] c_interval;
    logic c_irq;
    logic c_pwr_sw;

    poll_t poll_backlog[$];
    result_t pending_results[$];
    int polls_queued = 0;
    int results_seen = 0;
    int mismatches = 0;
    int n_setup_writes = 0;
    int n_samples = 0;
    int n_recoveries = 0;

    logic poll_taken = 1'b0;
    int send_gap = 0;
    int stall_left = 0;
    bit no_stall = 1'b0;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] init_entry(logic [3:0] k);
        logic [63:0] w;
        if (k >= INIT_ENTRIES_DEF)
            return 16'hFFFF;
        w = k[2] ? c_table_hi : c_table_lo;
        return w[k[1:0]*16 +: 16];
    endfunction

    function automatic result_t advance_sequencer(poll_t p);
        result_t r;
        logic [15:0] ent;
        logic [31:0] el;
        logic go;
        logic ok;
        r = '0;
        ok = 1'b0;
        if (p.start_req) begin
            if (c_pwr_sw)
                m_power = 1'b1;
            m_mode = PH_PWRWAIT;
            m_power_time = p.now_ms;
            m_init_idx = '0;
        end
        else begin
            case (m_mode)
                PH_PWRWAIT:
                begin
                    if (p.now_ms - m_power_time >= POWER_WAIT_MS) begin
                        m_mode = PH_SETUP;
                        m_init_idx = '0;
                    end
                end
                PH_SETUP:
                begin
                    ent = init_entry(m_init_idx);
                    r.filter_reset = 1'b1;
                    m_read_fails = '0;
                    if (ent[15:8] == TABLE_END) begin
                        m_ready = 1'b1;
                        m_mode = PH_RUN;
                        m_sample_time = p.now_ms;
                    end
                    else begin
                        r.bus_cmd = CMD_WRITE;
                        r.bus_len = 4'd2;
                        r.bus_first_byte = ent[15:8];
                        r.bus_second_byte = ent[7:0];
                        m_mode = PH_SETUPWAIT;
                        n_setup_writes++;
                    end
                end
                PH_SETUPWAIT:
                begin
                    if (!p.bus_busy) begin
                        if (!p.bus_error) begin
                            if (m_init_idx < INIT_ENTRIES_DEF)
                                m_init_idx++;
                        end
                        else begin
                            r.clear_error = 1'b1;
                            m_init_idx = '0;
                            if (m_setup_fails < SETUP_FAIL_LIMIT)
                                m_setup_fails++;
                            m_error = 1'b1;
                        end
                        m_mode = (m_setup_fails < SETUP_FAIL_LIMIT) ? PH_SETUP : PH_ERROR;
                    end
                end
                PH_RUN:
                begin
                    el = p.now_ms - m_sample_time;
                    go = (c_irq && p.irq_level && el >= {24'd0, c_interval} - 32'd1)
                        || el >= {24'd0, c_interval};
                    if (go) begin
                        m_sample_time = p.now_ms;
                        r.bus_cmd = CMD_WRITE;
                        r.bus_len = 4'd1;
                        r.bus_first_byte = c_read_reg;
                        m_mode = PH_ADDRWAIT;
                    end
                end
                PH_ADDRWAIT, PH_DATAWAIT:
                begin
                    if (m_mode == PH_ADDRWAIT) begin
                        if (!p.bus_busy && !p.bus_error) begin
                            r.bus_cmd = CMD_READ;
                            r.bus_len = 4'(READ_BYTES_DEF);
                            m_mode = PH_DATAWAIT;
                            ok = 1'b1;
                        end
                    end
                    else if (p.bus_result_ready) begin
                        m_read_fails = '0;
                        m_mode = PH_RUN;
                        r.take_result = 1'b1;
                        r.new_sample = 1'b1;
                        ok = 1'b1;
                        n_samples++;
                    end
                    if (!ok && p.now_ms - m_sample_time >= READ_TIMEOUT_MS) begin
                        r.clear_error = 1'b1;
                        if (m_read_fails < READ_FAIL_LIMIT) begin
                            m_read_fails++;
                            m_mode = PH_RUN;
                        end
                        else
                            m_mode = PH_ERROR;
                    end
                end
                PH_ERROR:
                begin
                    m_error = 1'b1;
                    m_init_idx = '0;
                    m_mode = PH_BUSRESET;
                    m_power_time = p.now_ms;
                    r.bus_cmd = CMD_STOP;
                    n_recoveries++;
                end
                PH_BUSRESET:
                begin
                    if (!p.bus_busy) begin
                        m_power_time = p.now_ms;
                        if (c_pwr_sw) begin
                            m_mode = PH_POWEROFF;
                            m_power = 1'b0;
                        end
                        else
                            m_mode = PH_PWRWAIT;
                    end
                end
                PH_POWEROFF:
                begin
                    if (p.now_ms - m_power_time >= POWER_WAIT_MS) begin
                        m_power_time = p.now_ms;
                        m_power = 1'b1;
                        m_mode = PH_PWRWAIT;
                    end
                end
                default: ;
            endcase
        end
        r.phase = m_mode;
        r.power_on = m_power;
        r.ready_res = m_ready;
        r.error_seen = m_error;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic add_poll(logic s, logic [31:0] t, logic b, logic e, logic d, logic q);
        poll_t p;
        p.start_req = s;
        p.now_ms = t;
        p.bus_busy = b;
        p.bus_error = e;
        p.bus_result_ready = d;
        p.irq_level = q;
        poll_backlog.push_back(p);
        polls_queued++;
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_INIT_TABLE_LOW: c_table_lo = val;
            REG_INIT_TABLE_HIGH: c_table_hi = val;
            REG_READ_START_REGISTER: c_read_reg = val[7:0];
            REG_SAMPLE_INTERVAL_MS: c_interval = val[7:0];
            REG_IRQ_PRESENT: c_irq = val[0];
            REG_POWER_SWITCH_PRESENT: c_pwr_sw = val[0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        wait (results_seen == polls_queued);
        repeat (4) @(posedge clk);
    endtask

    // live entries get a non-end register byte, the rest end the table
    function automatic logic [63:0] make_table(int live);
        logic [63:0] w;
        for (int k = 0; k < 4; k++) begin
            if (k < live)
                w[k*16 +: 16] = {8'($urandom_range(0, 254)), 8'($urandom)};
            else
                w[k*16 +: 16] = {TABLE_END, 8'($urandom)};
        end
        return w;
    endfunction

    always @(posedge clk) begin : check_and_predict
        result_t got;
        result_t want;
        poll_taken <= poll_bus.valid && poll_bus.ready;
        if (result_bus.valid && result_bus.ready) begin
            got = result_bus.data;
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result word with none expected: %h", got));
            else begin
                want = pending_results.pop_front();
                if (got.phase !== want.phase)
                    report_mismatch($sformatf("phase %0d, expected %0d", got.phase, want.phase));
                if (got.bus_cmd !== want.bus_cmd)
                    report_mismatch($sformatf("bus_cmd %0d, expected %0d",
                        got.bus_cmd, want.bus_cmd));
                if (got.bus_len !== want.bus_len)
                    report_mismatch($sformatf("bus_len %0d, expected %0d",
                        got.bus_len, want.bus_len));
                if (got.bus_first_byte !== want.bus_first_byte)
                    report_mismatch($sformatf("bus_first_byte %h, expected %h",
                        got.bus_first_byte, want.bus_first_byte));
                if (got.bus_second_byte !== want.bus_second_byte)
                    report_mismatch($sformatf("bus_second_byte %h, expected %h",
                        got.bus_second_byte, want.bus_second_byte));
                if (got.clear_error !== want.clear_error)
                    report_mismatch($sformatf("clear_error %b, expected %b",
                        got.clear_error, want.clear_error));
                if (got.take_result !== want.take_result)
                    report_mismatch($sformatf("take_result %b, expected %b",
                        got.take_result, want.take_result));
                if (got.power_on !== want.power_on)
                    report_mismatch($sformatf("power_on %b, expected %b",
                        got.power_on, want.power_on));
                if (got.filter_reset !== want.filter_reset)
                    report_mismatch($sformatf("filter_reset %b, expected %b",
                        got.filter_reset, want.filter_reset));
                if (got.ready_res !== want.ready_res)
                    report_mismatch($sformatf("ready_res %b, expected %b",
                        got.ready_res, want.ready_res));
                if (got.new_sample !== want.new_sample)
                    report_mismatch($sformatf("new_sample %b, expected %b",
                        got.new_sample, want.new_sample));
                if (got.error_seen !== want.error_seen)
                    report_mismatch($sformatf("error_seen %b, expected %b",
                        got.error_seen, want.error_seen));
            end
        end
        if (poll_bus.valid && poll_bus.ready)
            pending_results.push_back(advance_sequencer(poll_bus.data));
    end

    always @(negedge clk) begin : drive_polls
        if (!poll_bus.valid || poll_taken) begin
            if (send_gap != 0) begin
                poll_bus.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (poll_backlog.size() != 0) begin
                poll_bus.data <= poll_backlog.pop_front();
                poll_bus.valid <= 1'b1;
                send_gap <= no_stall ? 0 : pick_gap();
            end
            else
                poll_bus.valid <= 1'b0;
        end
    end

    always @(negedge clk) begin : drive_ready
        if (stall_left != 0) begin
            result_bus.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else begin
            result_bus.ready <= 1'b1;
            stall_left <= no_stall ? 0 : pick_gap();
        end
    end

    initial begin : watchdog
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] t;
        logic [6:0] dev;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [7:0] rd;
        logic [7:0] iv;
        logic irq_en;
        logic psw;
        int err_pct;
        int roll;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_DEVICE_ADDRESS;
        cfg_data = '0;
        poll_bus.valid = 1'b0;
        poll_bus.data = '0;
        result_bus.ready = 1'b0;

        c_table_lo = '1;
        c_table_hi = '1;
        c_read_reg = 8'd34;
        c_interval = 8'd9;
        c_irq = 1'b1;
        c_pwr_sw = 1'b1;
        m_mode = PH_IDLE;
        m_power_time = '0;
        m_sample_time = '0;
        m_init_idx = '0;
        m_read_fails = '0;
        m_setup_fails = '0;
        m_power = 1'b0;
        m_ready = 1'b0;
        m_error = 1'b0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset config, empty init table, time wraps through zero
        t = 32'hFFFF_FFF0;
        add_poll(0, 32'hFFFF_FFFF, 1, 1, 1, 1);
        add_poll(1, t, 0, 0, 0, 0);
        add_poll(0, t + 24, 0, 0, 0, 0);
        add_poll(0, t + 25, 0, 0, 0, 0);
        t = t + 25;
        add_poll(0, t, 0, 0, 0, 0);
        add_poll(0, t + 7, 0, 0, 0, 1);
        add_poll(0, t + 8, 0, 0, 0, 1);
        t = t + 8;
        add_poll(0, t, 1, 0, 0, 0);
        add_poll(0, t + 1, 0, 0, 0, 0);
        add_poll(0, t + 2, 0, 0, 0, 0);
        add_poll(0, t + 3, 0, 0, 1, 0);
        t = t + 12;
        add_poll(0, t, 0, 0, 0, 0);
        add_poll(0, t + 5, 0, 1, 0, 0);
        add_poll(0, t + 200, 0, 1, 0, 0);
        t = t + 209;
        add_poll(0, t, 0, 0, 0, 0);
        add_poll(0, t + 1, 0, 0, 0, 0);
        add_poll(0, t + 200, 0, 0, 0, 0);
        t = t + 209;
        add_poll(0, t, 0, 0, 0, 0);
        add_poll(0, t + 250, 1, 0, 0, 0);
        add_poll(0, t + 251, 0, 0, 0, 0);
        add_poll(0, t + 252, 1, 0, 0, 0);
        add_poll(0, t + 253, 0, 0, 0, 0);
        add_poll(0, t + 270, 0, 0, 0, 0);
        add_poll(0, t + 278, 0, 0, 0, 0);
        add_poll(1, t + 280, 1, 1, 1, 1);
        wait_idle();

        for (int ph = 0; ph < 7; ph++) begin
            no_stall = (ph == 2 || ph == 5);
            case (ph)
                0:
                begin
                    dev = 7'd106; lo = make_table(3); hi = make_table(0);
                    rd = 8'd34; iv = 8'd9; irq_en = 1'b1; psw = 1'b1; err_pct = 2;
                end
                1:
                begin
                    dev = 7'd0; lo = make_table(4); hi = make_table(4);
                    rd = 8'd0; iv = 8'd1; irq_en = 1'b0; psw = 1'b0; err_pct = 2;
                end
                2:
                begin
                    dev = 7'd127; lo = '1; hi = '1;
                    rd = 8'd255; iv = 8'd0; irq_en = 1'b1; psw = 1'b1; err_pct = 3;
                end
                3:
                begin
                    dev = 7'($urandom); lo = '0; hi = '0;
                    rd = 8'($urandom); iv = 8'd255; irq_en = 1'b1; psw = 1'b0; err_pct = 5;
                end
                4:
                begin
                    dev = 7'($urandom);
                    lo = make_table($urandom_range(0, 4));
                    hi = make_table($urandom_range(0, 4));
                    rd = 8'($urandom); iv = 8'($urandom_range(1, 255));
                    irq_en = 1'($urandom); psw = 1'($urandom); err_pct = 8;
                end
                5:
                begin
                    dev = 7'($urandom); lo = {$urandom, $urandom}; hi = {$urandom, $urandom};
                    rd = 8'($urandom); iv = 8'd11; irq_en = 1'b0; psw = 1'b1; err_pct = 10;
                end
                default:
                begin
                    dev = 7'($urandom);
                    lo = make_table($urandom_range(1, 4));
                    hi = make_table($urandom_range(0, 4));
                    rd = 8'($urandom); iv = 8'($urandom_range(1, 20));
                    irq_en = 1'b1; psw = 1'($urandom); err_pct = 15;
                end
            endcase
            write_reg(REG_DEVICE_ADDRESS, {57'd0, dev});
            write_reg(REG_INIT_TABLE_LOW, lo);
            write_reg(REG_INIT_TABLE_HIGH, hi);
            write_reg(REG_READ_START_REGISTER, {56'd0, rd});
            write_reg(REG_SAMPLE_INTERVAL_MS, {56'd0, iv});
            write_reg(REG_IRQ_PRESENT, {63'd0, irq_en});
            write_reg(REG_POWER_SWITCH_PRESENT, {63'd0, psw});

            t = (ph == 2) ? 32'hFFFF_FF00 : $urandom;
            for (int k = 0; k < 280; k++) begin
                if ($urandom_range(0, 99) == 0)
                    t = $urandom;
                else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 85)
                        t = t + $urandom_range(0, 3);
                    else if (roll < 97)
                        t = t + $urandom_range(4, 30);
                    else
                        t = t + $urandom_range(150, 400);
                end
                add_poll(k == 0 || $urandom_range(0, 149) == 0, t,
                    $urandom_range(0, 99) < 35, $urandom_range(0, 99) < err_pct,
                    $urandom_range(0, 99) < 30, $urandom_range(0, 99) < 30);
                if (ph == 3 && k == 140)
                    wait_idle();
            end
            wait_idle();
        end

        repeat (5) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d expected words never arrived",
                pending_results.size()));
        $display("Checked %0d result words for %0d polls: directed set plus 7 configurations.",
            results_seen, polls_queued);
        $display("Covered %0d init writes, %0d samples taken, %0d bus stop recoveries.",
            n_setup_writes, n_samples, n_recoveries);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
